### hdl/tls_pkg.sv
package tls_pkg;

	localparam int TS_W    = 64;
	localparam int CNT_W   = 32;
	localparam int CODE_W  = 32;
	localparam int OP_W    = 2;
	localparam int IN_W    = TS_W + CODE_W;
	localparam int OUT_W   = 3 * CNT_W + 8 * TS_W;
	localparam int DIV_STEPS = TS_W;
	localparam int STEP_W  = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_END   = 2'd1;
	localparam logic [OP_W-1:0] OP_ERROR = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic capture;   // latch the incoming word
		logic update;    // apply the event to start/end/count/error state
		logic accum;     // add elapsed to total, update min/max, seed divider
		logic div_step;  // one restoring division step
		logic load;      // copy statistics into the output register
	} cmd_t;

endpackage

### hdl/transaction_latency_stats_unit.sv
// An accepted input word passes through update, accumulate, 64 steps of the
// bit-serial average divider and a load into the output register.
// No new word is taken before the previous result is loaded.
// The next word is taken while the previous result waits in the output register.
// arst_n clears all statistics to zero and empties the output register.
module transaction_latency_stats_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// timestamp_us[63:0], fault_code[95:64]
	input  logic [tls_pkg::IN_W-1:0]    s_tdata,
	// opcode[1:0]
	input  logic [tls_pkg::OP_W-1:0]    s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// event_count[31:0], error_total[63:32], last_error[95:64],
	// first_start_us[159:96], start_us[223:160], end_us[287:224],
	// last_elapsed_us[351:288], total_elapsed_us[415:352],
	// max_elapsed_us[479:416], min_elapsed_us[543:480], avg_elapsed_us[607:544]
	output logic [tls_pkg::OUT_W-1:0]   m_tdata
);
	import tls_pkg::*;

	cmd_t cmd;

	tls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.in_op    (s_tuser),
		.out_data (m_tdata)
	);

endmodule

### hdl/tls_ctrl.sv
module tls_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output tls_pkg::cmd_t cmd
);
	import tls_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	// the output register is free when empty or being drained this cycle
	assign load     = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		cmd          = '0;
		cmd.capture  = s_tvalid && s_tready;
		cmd.update   = (state_q == ST_UPD);
		cmd.accum    = (state_q == ST_ACC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load     = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/tls_dp.sv
module tls_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tls_pkg::cmd_t              cmd,
	input  logic [tls_pkg::IN_W-1:0]   in_data,
	input  logic [tls_pkg::OP_W-1:0]   in_op,
	output logic [tls_pkg::OUT_W-1:0]  out_data
);
	import tls_pkg::*;

	logic [OP_W-1:0]   op_s1;
	logic [TS_W-1:0]   ts_s1;
	logic [CODE_W-1:0] code_s1;

	logic [TS_W-1:0]   first_q, start_q, end_q, elapsed_q, total_q, max_q, min_q;
	logic [CNT_W-1:0]  done_q, errcnt_q;
	logic [CODE_W-1:0] errcode_q;

	logic [TS_W-1:0]   total_nxt;
	logic [TS_W-1:0]   quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    rem_shift;
	logic              fits;
	logic [TS_W-1:0]   avg;
	logic [OUT_W-1:0]  out_q;

	assign total_nxt = total_q + elapsed_q;
	assign rem_shift = {rem_q, quo_q[TS_W-1]};
	assign fits      = rem_shift >= {1'b0, done_q};
	assign avg       = (done_q == '0) ? '0 : quo_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= in_op;
			ts_s1   <= in_data[TS_W-1:0];
			code_s1 <= in_data[IN_W-1:TS_W];
		end
		if (cmd.accum) begin
			// total is only updated in this same cycle, so an end event seeds the dividend with total_nxt
			quo_q <= (op_s1 == OP_END) ? total_nxt : total_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[TS_W-2:0], fits};
			rem_q <= fits ? CNT_W'(rem_shift - {1'b0, done_q}) : rem_shift[CNT_W-1:0];
		end
		if (cmd.load) begin
			out_q <= {avg, min_q, max_q, total_q, elapsed_q, end_q, start_q, first_q,
				errcode_q, errcnt_q, done_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			start_q   <= '0;
			end_q     <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
			max_q     <= '0;
			min_q     <= '0;
			done_q    <= '0;
			errcnt_q  <= '0;
			errcode_q <= '0;
		end else begin
			if (cmd.update) begin
				case (op_s1)
					OP_START: begin
						errcode_q <= '0;
						start_q   <= ts_s1;
						if (first_q == '0) begin
							first_q <= ts_s1;
						end
					end
					OP_END: begin
						end_q     <= ts_s1;
						done_q    <= done_q + 1'b1;
						elapsed_q <= ts_s1 - start_q;
					end
					OP_ERROR: begin
						errcode_q <= code_s1;
						errcnt_q  <= errcnt_q + 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.accum && op_s1 == OP_END) begin
				total_q <= total_nxt;
				if (done_q == CNT_W'(1)) begin
					max_q <= elapsed_q;
					min_q <= elapsed_q;
				end else begin
					if (elapsed_q > max_q) begin
						max_q <= elapsed_q;
					end
					if (elapsed_q < min_q) begin
						min_q <= elapsed_q;
					end
				end
			end
		end
	end

endmodule

### hdl/tls_checker.sv
module tls_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tls_pkg::OUT_W-1:0] m_tdata
);
	import tls_pkg::*;

	// one event in flight: input stays closed while the accepted word is in update and accumulate
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
		else $error("input taken while previous event still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result word changed or dropped");

	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:0] != '0) |-> (m_tdata[607:544] <= m_tdata[415:352]))
		else $error("average exceeds total");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[543:480] <= m_tdata[479:416]))
		else $error("min elapsed above max elapsed");

endmodule

bind transaction_latency_stats_unit tls_checker u_tls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/transaction_latency_stats_unit_tb.sv
`timescale 1ns / 1ps

module transaction_latency_stats_unit_tb;
	import tls_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;

	// same bit order as m_tdata: event_count in the low bits, average on top
	typedef struct packed {
		logic [63:0]        avg_elapsed_us;
		logic [63:0]        min_elapsed_us;
		logic [63:0]        max_elapsed_us;
		logic [63:0]        total_elapsed_us;
		logic [63:0]        last_elapsed_us;
		logic [63:0]        end_us;
		logic [63:0]        start_us;
		logic [63:0]        first_start_us;
		logic signed [31:0] last_error;
		logic [31:0]        error_total;
		logic [31:0]        event_count;
	} stats_t;

	typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_e;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic [OP_W-1:0]   s_tuser  = OP_READ;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// monitor state as the block should hold it
	logic [63:0] t_first, t_start, t_end, t_elapsed, t_total, t_max, t_min;
	logic [31:0] n_done, n_err, err_last;

	stats_t pending_stats[$];
	int     mismatches   = 0;
	int     words_seen   = 0;
	int     cycle_count  = 0;
	int     op_seen[4]   = '{default: 0};
	int     hold_reqs    = 0;
	int     holds_done   = 0;
	bit     pacing       = 1'b0;
	int     burst_left   = 0;

	transaction_latency_stats_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic stats_t apply_event(input logic [1:0] op, input logic [63:0] ts,
			input logic [31:0] code);
		stats_t r;
		case (op)
			OP_START: begin
				err_last = '0;
				t_start  = ts;
				if (t_first == 64'd0)
					t_first = ts;
			end
			OP_END: begin
				t_end     = ts;
				n_done    = n_done + 32'd1;
				t_elapsed = t_end - t_start;
				t_total   = t_total + t_elapsed;
				if (n_done == 32'd1) begin
					t_max = t_elapsed;
					t_min = t_elapsed;
				end else begin
					if (t_elapsed > t_max)
						t_max = t_elapsed;
					if (t_elapsed < t_min)
						t_min = t_elapsed;
				end
			end
			OP_ERROR: begin
				err_last = code;
				n_err    = n_err + 32'd1;
			end
			default: ;
		endcase
		r.event_count      = n_done;
		r.error_total      = n_err;
		r.last_error       = err_last;
		r.first_start_us   = t_first;
		r.start_us         = t_start;
		r.end_us           = t_end;
		r.last_elapsed_us  = t_elapsed;
		r.total_elapsed_us = t_total;
		r.max_elapsed_us   = t_max;
		r.min_elapsed_us   = t_min;
		r.avg_elapsed_us   = (n_done == 32'd0) ? 64'd0 : t_total / {32'd0, n_done};
		return r;
	endfunction

	function automatic logic [63:0] next_step();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 50));
			3: return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
			default: return 64'($urandom_range(0, 100000));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// one word in, stats predicted when it is taken
	task automatic send_event(input logic [1:0] op, input logic [63:0] ts,
			input logic [31:0] code);
		int gap;
		if (pacing) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
					: $urandom_range(0, 20);
				burst_left = $urandom_range(1, 12);
				if (gap > 0) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					s_tdata  = {$urandom, $urandom, $urandom};
					s_tuser  = OP_W'($urandom);
					repeat (gap - 1) @(negedge clk);
				end
			end
			burst_left--;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {code, ts};
		do @(posedge clk); while (!s_tready);
		pending_stats.push_back(apply_event(op, ts, code));
		op_seen[op]++;
	endtask

	// ignored fields carry noise so the block must not depend on them
	task automatic test_directed_corners();
		send_event(OP_READ,  '1, '1);
		send_event(OP_END,   64'd100, 32'h1234_5678);          // end without start
		send_event(OP_ERROR, 64'hDEAD_BEEF_0000_0001, 32'h7FFF_FFFF);
		send_event(OP_ERROR, '1, 32'h8000_0000);
		send_event(OP_START, 64'd0, 32'hFFFF_FFFF);             // start at zero, first stays 0
		send_event(OP_END,   64'd0, '0);                        // zero elapsed
		send_event(OP_START, 64'hFFFF_FFFF_FFFF_FFF0, '0);      // now first latches
		send_event(OP_END,   64'd5, '0);                        // end wraps past 2^64
		send_event(OP_START, 64'd1000, '0);
		send_event(OP_END,   64'd500, '0);                      // time going backwards
		send_event(OP_START, 64'd0, '0);
		send_event(OP_END,   '1, '0);                           // largest elapsed
		send_event(OP_ERROR, '0, '1);
		send_event(OP_READ,  '0, '0);
		send_event(OP_ERROR, '1, '0);
		send_event(OP_START, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		send_event(OP_END,   64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		send_event(OP_READ,  64'h0123_4567_89AB_CDEF, 32'hCAFE_F00D);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [63:0] now_us;
		int          sent;
		int          pick;
		now_us = {$urandom, $urandom};
		sent   = 0;
		pacing = 1'b1;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_event(OP_START, now_us, $urandom);
				now_us = now_us + next_step();
				if ($urandom_range(0, 9) == 0) begin
					send_event(OP_ERROR, {$urandom, $urandom}, $urandom);
					sent++;
				end
				send_event(OP_END, now_us, $urandom);
				now_us = now_us + next_step();
				sent += 2;
			end else begin
				if (pick < 77)
					send_event(OP_ERROR, {$urandom, $urandom}, $urandom);
				else if (pick < 85)
					send_event(OP_READ, {$urandom, $urandom}, $urandom);
				else if (pick < 92)
					send_event(OP_END, {$urandom, $urandom}, $urandom);
				else if (pick < 97)
					send_event(OP_START, {$urandom, $urandom}, $urandom);
				else
					send_event(OP_START, 64'd0, $urandom);
				sent++;
			end
			if ($urandom_range(0, 49) == 0)
				now_us = {$urandom, $urandom};
		end
		pacing = 1'b0;
	endtask

	// receiver holds off long enough that the block backs up into s_tready
	task automatic test_pressure();
		@(posedge clk);
		hold_reqs++;
		repeat (12)
			send_event(OP_W'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
	endtask

	initial begin : receiver
		rx_mode_e mode;
		int       left;
		mode = RX_STEADY;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 2));
					left = $urandom_range(5, 150);
				end
				left--;
				case (mode)
					RX_STEADY: m_tready = 1'b1;
					RX_LIGHT:  m_tready = ($urandom_range(0, 3) != 0);
					default:   m_tready = $urandom_range(0, 1);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		stats_t exp_w;
		stats_t got_w;
		if (arst_n && m_tvalid && m_tready) begin
			got_w = stats_t'(m_tdata);
			words_seen++;
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time,
					m_tdata);
				mismatches++;
			end else begin
				exp_w = pending_stats.pop_front();
				check_field("event_count",      exp_w.event_count,      got_w.event_count);
				check_field("error_total",      exp_w.error_total,      got_w.error_total);
				check_field("last_error",       exp_w.last_error,       got_w.last_error);
				check_field("first_start_us",   exp_w.first_start_us,   got_w.first_start_us);
				check_field("start_us",         exp_w.start_us,         got_w.start_us);
				check_field("end_us",           exp_w.end_us,           got_w.end_us);
				check_field("last_elapsed_us",  exp_w.last_elapsed_us,  got_w.last_elapsed_us);
				check_field("total_elapsed_us", exp_w.total_elapsed_us,
					got_w.total_elapsed_us);
				check_field("max_elapsed_us",   exp_w.max_elapsed_us,   got_w.max_elapsed_us);
				check_field("min_elapsed_us",   exp_w.min_elapsed_us,   got_w.min_elapsed_us);
				check_field("avg_elapsed_us",   exp_w.avg_elapsed_us,   got_w.avg_elapsed_us);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d result words still outstanding", $time,
				pending_stats.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		{t_first, t_start, t_end, t_elapsed, t_total, t_max, t_min} = '0;
		{n_done, n_err, err_last} = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_corners();
		test_random_traffic(560);
		test_pressure();

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d start, %0d end, %0d error and %0d read events,",
			op_seen[OP_START], op_seen[OP_END], op_seen[OP_ERROR], op_seen[OP_READ]);
		$display("with random gaps, receiver stalls and one long hold-off; %0d words checked.",
			words_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
hdl/tls_pkg.sv
hdl/tls_ctrl.sv
hdl/tls_dp.sv
hdl/transaction_latency_stats_unit.sv
hdl/tls_checker.sv
sim/transaction_latency_stats_unit_tb.sv
